// File: rtl/bracket_csv_packet_parser_macros.svh
// assertion macros for the bracketed packet parser
`ifndef BRACKET_CSV_PACKET_PARSER_MACROS_SVH
`define BRACKET_CSV_PACKET_PARSER_MACROS_SVH

`ifndef SYNTH
// implication in the same cycle
`define BCPP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcpp assertion failed");
// implication in the following cycle
`define BCPP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcpp assertion failed");
`else
`define BCPP_ASSERT_SAME(lbl, ante, cons)
`define BCPP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/bcpp_pkg.sv
package bcpp_pkg;

    // default sizes
    localparam int BUF_LEN_DEF    = 64;
    localparam int MAX_FIELDS_DEF = 8;
    localparam int FIELD_LEN_DEF  = 16;

    // framing characters
    localparam logic [7:0] OPEN_CH  = 8'h5B;
    localparam logic [7:0] CLOSE_CH = 8'h5D;
    localparam logic [7:0] SEP_CH   = 8'h2C;

    // request codes
    localparam logic REQ_BYTE  = 1'b0;
    localparam logic REQ_RESET = 1'b1;

    // result kinds
    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] byte_value;
    } req_t;

    typedef struct packed {
        logic       result_kind;
        logic [2:0] field_index;
        logic [3:0] char_position;
        logic [7:0] char_value;
        logic [3:0] field_count;
        logic       packet_valid;
        logic       last_of_run;
    } res_t;

endpackage

// File: rtl/bcpp_store.sv
module bcpp_store #(
    parameter int DEPTH = bcpp_pkg::BUF_LEN_DEF - 1,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);
    import bcpp_pkg::*;

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // byte store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/bcpp_splitter.sv
`include "bracket_csv_packet_parser_macros.svh"

module bcpp_splitter #(
    parameter int MAX_FIELDS = bcpp_pkg::MAX_FIELDS_DEF,
    parameter int FIELD_LEN  = bcpp_pkg::FIELD_LEN_DEF,
    parameter int LW         = 6,
    parameter int AW         = 6
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [LW-1:0]  start_len,
    output logic [AW-1:0]  rd_addr,
    input  logic [7:0]     rd_data,
    output logic           busy,
    output logic           out_valid,
    input  logic           out_ready,
    output bcpp_pkg::res_t out_item
);
    import bcpp_pkg::*;

    localparam int FW = $clog2(MAX_FIELDS + 1);
    localparam int CW = $clog2(FIELD_LEN);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_SUM   = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [FW-1:0] fidx_reg, fidx_next;
    logic [CW-1:0] cidx_reg, cidx_next;
    logic          out_valid_reg, out_valid_next;
    res_t          out_item_reg, out_item_next;

    logic          out_free;
    logic          is_sep;
    logic [FW-1:0] fidx_after;
    logic [LW-1:0] idx_inc;
    logic [FW-1:0] count;

    assign out_free   = !out_valid_reg || out_ready;
    assign is_sep     = (rd_data == SEP_CH);
    assign fidx_after = is_sep ? fidx_reg + FW'(1) : fidx_reg;
    assign idx_inc    = idx_reg + LW'(1);
    assign count      = ((fidx_reg < FW'(MAX_FIELDS)) && (cidx_reg != '0))
                        ? fidx_reg + FW'(1) : fidx_reg;

    // sequencer: read a byte, evaluate it, emit at most one result per step
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        fidx_next      = fidx_reg;
        cidx_next      = cidx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    len_next   = start_len;
                    idx_next   = '0;
                    fidx_next  = '0;
                    cidx_next  = '0;
                    state_next = (start_len == '0) ? S_SUM : S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (out_free)
                begin
                    if (is_sep)
                    begin
                        fidx_next = fidx_after;
                        cidx_next = '0;
                    end
                    else if (cidx_reg < CW'(FIELD_LEN - 1))
                    begin
                        out_valid_next              = 1'b1;
                        out_item_next.result_kind   = KIND_CHAR;
                        out_item_next.field_index   = 3'(fidx_reg);
                        out_item_next.char_position = 4'(cidx_reg);
                        out_item_next.char_value    = rd_data;
                        out_item_next.field_count   = '0;
                        out_item_next.packet_valid  = 1'b0;
                        out_item_next.last_of_run   = 1'b0;
                        cidx_next                   = cidx_reg + CW'(1);
                    end
                    idx_next   = idx_inc;
                    state_next = ((idx_inc < len_reg) && (fidx_after < FW'(MAX_FIELDS)))
                                 ? S_READ : S_SUM;
                end
            end
            S_SUM:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_item_next.result_kind   = KIND_SUMMARY;
                    out_item_next.field_index   = '0;
                    out_item_next.char_position = '0;
                    out_item_next.char_value    = '0;
                    out_item_next.field_count   = 4'(count);
                    out_item_next.packet_valid  = (count != '0);
                    out_item_next.last_of_run   = 1'b1;
                    state_next                  = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            len_reg       <= '0;
            idx_reg       <= '0;
            fidx_reg      <= '0;
            cidx_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            fidx_reg      <= fidx_next;
            cidx_reg      <= cidx_next;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign rd_addr   = AW'(idx_reg);
    assign busy      = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `BCPP_ASSERT_SAME(a_idle_no_result, state_reg == S_IDLE, !out_valid_reg)
    `BCPP_ASSERT_SAME(a_summary_in_drain, out_valid_reg && out_item_reg.last_of_run,
                      state_reg == S_DRAIN)
    `BCPP_ASSERT_SAME(a_field_bound, state_reg != S_IDLE, fidx_reg <= FW'(MAX_FIELDS))

endmodule

// File: rtl/bracket_csv_packet_parser.sv
// channel | handshake               | payload
// --------+-------------------------+---------------------------
// in      | in_valid / in_ready     | in_item  (bcpp_pkg::req_t)
// out     | out_valid / out_ready   | out_item (bcpp_pkg::res_t)
//
// a data byte or reset request is taken whenever in_valid and in_ready are both high
// a closing bracket starts the split: each stored byte is read from the store
// (S_READ), then compared and counted (S_EVAL), then the summary is sent (S_SUM)
// and transferred (S_DRAIN); S_EVAL and S_SUM wait while out_ready stalls
// in_ready is low from the closing bracket until the summary is transferred
// rst_n clears frame state, length and sequencer; stored bytes are not cleared
`include "bracket_csv_packet_parser_macros.svh"

module bracket_csv_packet_parser #(
    parameter int BUF_LEN    = bcpp_pkg::BUF_LEN_DEF,
    parameter int MAX_FIELDS = bcpp_pkg::MAX_FIELDS_DEF,
    parameter int FIELD_LEN  = bcpp_pkg::FIELD_LEN_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  bcpp_pkg::req_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output bcpp_pkg::res_t out_item
);
    import bcpp_pkg::*;

    localparam int DEPTH = BUF_LEN - 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = $clog2(BUF_LEN);

    logic          frame_reg, frame_next;
    logic [LW-1:0] len_reg, len_next;
    logic          in_fire;
    logic          wr_en;
    logic          start;
    logic          busy;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    assign in_ready = !busy;
    assign in_fire  = in_valid && in_ready;

    // framing: wait for open bracket, store bytes, start split on close, drop frame on overflow or reset
    always_comb
    begin
        frame_next = frame_reg;
        len_next   = len_reg;
        wr_en      = 1'b0;
        start      = 1'b0;
        if (in_fire)
        begin
            priority if (in_item.req_type == REQ_RESET)
            begin
                frame_next = 1'b0;
                len_next   = '0;
            end
            else if (!frame_reg)
            begin
                if (in_item.byte_value == OPEN_CH)
                begin
                    frame_next = 1'b1;
                    len_next   = '0;
                end
            end
            else if (in_item.byte_value == CLOSE_CH)
            begin
                start      = 1'b1;
                frame_next = 1'b0;
                len_next   = '0;
            end
            else if (len_reg < LW'(BUF_LEN - 1))
            begin
                wr_en    = 1'b1;
                len_next = len_reg + LW'(1);
            end
            else
            begin
                frame_next = 1'b0;
                len_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= 1'b0;
            len_reg   <= '0;
        end
        else
        begin
            frame_reg <= frame_next;
            len_reg   <= len_next;
        end
    end

    // packet byte store
    bcpp_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (AW'(len_reg)),
        .wr_data (in_item.byte_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // field splitter with result register
    bcpp_splitter #(
        .MAX_FIELDS (MAX_FIELDS),
        .FIELD_LEN  (FIELD_LEN),
        .LW         (LW),
        .AW         (AW)
    ) u_splitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .start_len (len_reg),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .busy      (busy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    `BCPP_ASSERT_SAME(a_len_bound, frame_reg, len_reg <= LW'(BUF_LEN - 1))
    `BCPP_ASSERT_NEXT(a_start_blocks_input, start, !in_ready)
    `BCPP_ASSERT_SAME(a_write_in_frame, wr_en, frame_reg && in_fire)

endmodule
